@@ rtl/core/msort_pkg.sv @@
package msort_pkg;

    // capacity and widths
    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] word_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_RUN,
        S_RD,
        S_CMP,
        S_EMIT_RD,
        S_EMIT_SHOW
    } state_t;

    // bank codes
    localparam logic BANK_MAIN    = 1'b0;
    localparam logic BANK_SCRATCH = 1'b1;

    // memory command from the sequencer
    typedef struct packed {
        logic  wr_en;
        logic  wr_bank;
        idx_t  wr_addr;
        word_t wr_data;
        idx_t  rd_addr0;
        idx_t  rd_addr1;
    } mem_cmd_t;

    // read data of both banks, both ports
    typedef struct packed {
        word_t main0;
        word_t main1;
        word_t scr0;
        word_t scr1;
    } mem_rsp_t;

endpackage

@@ rtl/core/msort_ram.sv @@
module msort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr0,
    input  logic [AW-1:0]    raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

@@ rtl/core/msort_ctrl.sv @@
module msort_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [msort_pkg::DATA_W-1:0] s_value,
    input  logic                         s_last,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [msort_pkg::DATA_W-1:0] m_sorted_value,
    output logic                         m_end_of_set,
    output logic                         m_overflow,
    output msort_pkg::mem_cmd_t          cmd,
    input  msort_pkg::mem_rsp_t          rsp
);

    msort_pkg::state_t state_reg, state_next;
    msort_pkg::cnt_t   cnt_reg, cnt_next;
    logic              drop_reg, drop_next;
    logic              dir_reg, dir_next;
    msort_pkg::cnt_t   width_reg, width_next;
    msort_pkg::cnt_t   lo_reg, lo_next;
    msort_pkg::cnt_t   mid_reg, mid_next;
    msort_pkg::cnt_t   hi_reg, hi_next;
    msort_pkg::cnt_t   i_reg, i_next;
    msort_pkg::cnt_t   j_reg, j_next;
    msort_pkg::cnt_t   k_reg, k_next;
    msort_pkg::idx_t   e_reg, e_next;

    logic                     in_xfer;
    logic                     out_xfer;
    logic                     full;
    msort_pkg::cnt_t          cnt_after;
    logic [msort_pkg::CNT_W:0] mid_sum;
    logic [msort_pkg::CNT_W:0] hi_sum;
    logic [msort_pkg::CNT_W:0] width_dbl;
    logic [msort_pkg::CNT_W:0] lo_step;
    msort_pkg::word_t         head_a;
    msort_pkg::word_t         head_b;
    logic                     take_a;
    logic                     run_done;
    logic                     pass_done;
    logic                     sort_done;
    logic                     emit_done;

    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;

    // load bookkeeping
    assign full      = (cnt_reg == msort_pkg::CNT_W'(msort_pkg::MAX_ITEMS));
    assign cnt_after = full ? cnt_reg : cnt_reg + 1'b1;

    // run bounds, clipped to the set size
    assign width_dbl = {1'b0, width_reg} << 1;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, width_reg};
    assign hi_sum    = {1'b0, lo_reg} + width_dbl;
    assign lo_step   = hi_sum;

    // heads of both runs come from the source bank
    assign head_a = (dir_reg == msort_pkg::BANK_MAIN) ? rsp.main0 : rsp.scr0;
    assign head_b = (dir_reg == msort_pkg::BANK_MAIN) ? rsp.main1 : rsp.scr1;

    // stable pick: left run wins ties
    assign take_a = (i_reg < mid_reg) &&
                    ((j_reg >= hi_reg) || ($signed(head_a) <= $signed(head_b)));

    assign run_done  = (k_reg + 1'b1 == hi_reg);
    assign pass_done = (lo_step >= {1'b0, cnt_reg});
    assign sort_done = (width_dbl >= {1'b0, cnt_reg});
    assign emit_done = ({1'b0, e_reg} + 1'b1 == cnt_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msort_pkg::S_LOAD: begin
                if (in_xfer && s_last) begin
                    state_next = (cnt_after > msort_pkg::CNT_W'(1)) ? msort_pkg::S_RUN
                                                                     : msort_pkg::S_EMIT_RD;
                end
            end
            msort_pkg::S_RUN: begin
                state_next = msort_pkg::S_RD;
            end
            msort_pkg::S_RD: begin
                state_next = msort_pkg::S_CMP;
            end
            msort_pkg::S_CMP: begin
                priority if (!run_done) begin
                    state_next = msort_pkg::S_RD;
                end else if (!pass_done) begin
                    state_next = msort_pkg::S_RUN;
                end else if (!sort_done) begin
                    state_next = msort_pkg::S_RUN;
                end else begin
                    state_next = msort_pkg::S_EMIT_RD;
                end
            end
            msort_pkg::S_EMIT_RD: begin
                state_next = msort_pkg::S_EMIT_SHOW;
            end
            msort_pkg::S_EMIT_SHOW: begin
                if (out_xfer) begin
                    state_next = emit_done ? msort_pkg::S_LOAD : msort_pkg::S_EMIT_RD;
                end
            end
            default: state_next = msort_pkg::S_LOAD;
        endcase
    end

    // pointer and counter updates
    always_comb begin
        cnt_next   = cnt_reg;
        drop_next  = drop_reg;
        dir_next   = dir_reg;
        width_next = width_reg;
        lo_next    = lo_reg;
        mid_next   = mid_reg;
        hi_next    = hi_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        e_next     = e_reg;
        unique case (state_reg)
            msort_pkg::S_LOAD: begin
                if (in_xfer) begin
                    cnt_next  = cnt_after;
                    drop_next = drop_reg | full;
                    if (s_last) begin
                        dir_next   = msort_pkg::BANK_MAIN;
                        width_next = msort_pkg::CNT_W'(1);
                        lo_next    = '0;
                        e_next     = '0;
                    end
                end
            end
            msort_pkg::S_RUN: begin
                mid_next = (mid_sum > {1'b0, cnt_reg}) ? cnt_reg : mid_sum[msort_pkg::CNT_W-1:0];
                hi_next  = (hi_sum > {1'b0, cnt_reg}) ? cnt_reg : hi_sum[msort_pkg::CNT_W-1:0];
                i_next   = lo_reg;
                j_next   = (mid_sum > {1'b0, cnt_reg}) ? cnt_reg : mid_sum[msort_pkg::CNT_W-1:0];
                k_next   = lo_reg;
            end
            msort_pkg::S_RD: begin
            end
            msort_pkg::S_CMP: begin
                k_next = k_reg + 1'b1;
                if (take_a) begin
                    i_next = i_reg + 1'b1;
                end else begin
                    j_next = j_reg + 1'b1;
                end
                if (run_done) begin
                    if (pass_done) begin
                        // pass over: swap banks and double the run width
                        dir_next   = ~dir_reg;
                        width_next = width_dbl[msort_pkg::CNT_W-1:0];
                        lo_next    = '0;
                        e_next     = '0;
                    end else begin
                        lo_next = lo_step[msort_pkg::CNT_W-1:0];
                    end
                end
            end
            msort_pkg::S_EMIT_RD: begin
            end
            msort_pkg::S_EMIT_SHOW: begin
                if (out_xfer) begin
                    if (emit_done) begin
                        cnt_next  = '0;
                        drop_next = 1'b0;
                        dir_next  = msort_pkg::BANK_MAIN;
                    end else begin
                        e_next = e_reg + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // outputs and memory commands
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.wr_bank  = msort_pkg::BANK_MAIN;
        cmd.wr_addr  = cnt_reg[msort_pkg::IDX_W-1:0];
        cmd.wr_data  = s_value;
        cmd.rd_addr0 = e_reg;
        cmd.rd_addr1 = j_reg[msort_pkg::IDX_W-1:0];
        unique case (state_reg)
            msort_pkg::S_LOAD: begin
                s_ready   = 1'b1;
                cmd.wr_en = s_valid && !full;
            end
            msort_pkg::S_RUN: begin
            end
            msort_pkg::S_RD: begin
                cmd.rd_addr0 = i_reg[msort_pkg::IDX_W-1:0];
                cmd.rd_addr1 = j_reg[msort_pkg::IDX_W-1:0];
            end
            msort_pkg::S_CMP: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_bank = ~dir_reg;
                cmd.wr_addr = k_reg[msort_pkg::IDX_W-1:0];
                cmd.wr_data = take_a ? head_a : head_b;
            end
            msort_pkg::S_EMIT_RD: begin
            end
            msort_pkg::S_EMIT_SHOW: begin
                m_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result payload straight from the registered read port
    assign m_sorted_value = head_a;
    assign m_end_of_set   = emit_done;
    assign m_overflow     = drop_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msort_pkg::S_LOAD;
            cnt_reg   <= '0;
            drop_reg  <= 1'b0;
            dir_reg   <= msort_pkg::BANK_MAIN;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            drop_reg  <= drop_next;
            dir_reg   <= dir_next;
        end
    end

    // pointers need no reset
    always_ff @(posedge aclk) begin
        width_reg <= width_next;
        lo_reg    <= lo_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        e_reg     <= e_next;
    end

endmodule

@@ rtl/core/merge_sorter_unit.sv @@
// channel  | ports                                         | direction
// ---------+-----------------------------------------------+----------
// input    | s_valid s_ready s_value s_last                | in
// result   | m_valid m_ready m_sorted_value m_end_of_set   | out
//          | m_overflow                                    |
//
// loading takes one cycle per transaction; items past 64 are dropped
// sorting: ceil(log2 n) passes, each setting up every run in S_RUN, with each element
// bound by the two-step read/compare loop over the bank read ports
// emission: each result is read, then shown from the read register
// no clearing pass after reset; a stalled result holds the whole block
module merge_sorter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [msort_pkg::DATA_W-1:0] s_value,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [msort_pkg::DATA_W-1:0] m_sorted_value,
    output logic                                m_end_of_set,
    output logic                                m_overflow
);

    msort_pkg::mem_cmd_t cmd;
    msort_pkg::mem_rsp_t rsp;
    logic                main_we;
    logic                scr_we;

    // bank write enables
    assign main_we = cmd.wr_en && (cmd.wr_bank == msort_pkg::BANK_MAIN);
    assign scr_we  = cmd.wr_en && (cmd.wr_bank == msort_pkg::BANK_SCRATCH);

    msort_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value        (s_value),
        .s_last         (s_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_end_of_set   (m_end_of_set),
        .m_overflow     (m_overflow),
        .cmd            (cmd),
        .rsp            (rsp)
    );

    // main bank: holds the loaded set
    msort_ram #(
        .WIDTH (msort_pkg::DATA_W),
        .DEPTH (msort_pkg::MAX_ITEMS)
    ) u_main_ram (
        .aclk   (aclk),
        .we     (main_we),
        .waddr  (cmd.wr_addr),
        .wdata  (cmd.wr_data),
        .raddr0 (cmd.rd_addr0),
        .raddr1 (cmd.rd_addr1),
        .rdata0 (rsp.main0),
        .rdata1 (rsp.main1)
    );

    // scratch bank: merge target on alternate passes
    msort_ram #(
        .WIDTH (msort_pkg::DATA_W),
        .DEPTH (msort_pkg::MAX_ITEMS)
    ) u_scr_ram (
        .aclk   (aclk),
        .we     (scr_we),
        .waddr  (cmd.wr_addr),
        .wdata  (cmd.wr_data),
        .raddr0 (cmd.rd_addr0),
        .raddr1 (cmd.rd_addr1),
        .rdata0 (rsp.scr0),
        .rdata1 (rsp.scr1)
    );

`ifndef SYNTHESIS
    // loading and emission never overlap
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and result sides active together");

    // a result that does not close the set keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_end_of_set) |=> !s_ready)
        else $error("input reopened before set was emitted");

    // the closing result returns the block to loading
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_end_of_set) |=> (s_ready && !m_valid))
        else $error("block not idle after closing result");
`endif

endmodule
